[rtl/lss_pkg.sv]
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, codes and types of the stack with value search.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int FIELD_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

[rtl/lss_cell.sv]
// ----------------------------------------------------------------------------
// lss_cell
// One stack entry: shifts down on push, up on pop, compares against the key.
// ----------------------------------------------------------------------------
module lss_cell (
  input  logic                        clk,
  input  lss_pkg::shift_t             ctrl,
  input  logic signed [lss_pkg::VAL_W-1:0] above_value,
  input  logic signed [lss_pkg::VAL_W-1:0] below_value,
  input  logic signed [lss_pkg::VAL_W-1:0] key,
  output logic signed [lss_pkg::VAL_W-1:0] value,
  output logic                        match
);
  import lss_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      value <= above_value;
    end else if (ctrl.pop) begin
      value <= below_value;
    end
  end

  assign match = (value == key);

endmodule

[rtl/lss_find.sv]
// ----------------------------------------------------------------------------
// lss_find
// Picks the occupied matching cell nearest the top, 1-based position.
// ----------------------------------------------------------------------------
module lss_find (
  input  logic [lss_pkg::DEPTH-1:0] match,
  input  logic [lss_pkg::DEPTH-1:0] occupied,
  output logic                      found,
  output logic [lss_pkg::CNT_W-1:0] position
);
  import lss_pkg::*;

  logic [DEPTH-1:0] hit;

  assign hit   = match & occupied;
  assign found = |hit;

  // scan from the bottom so the topmost hit wins
  always_comb begin
    position = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        position = CNT_W'(i + 1);
      end
    end
  end

endmodule

[rtl/lifo_stack_with_search_top.sv]
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top
// Bounded stack of signed 32-bit values with push, pop, search and clear.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream: s_tuser carries the command (push, pop,
// search, clear) and s_tdata the value pushed or searched for. Each command
// yields exactly one result on the m_ stream: m_tuser carries the status and
// m_tdata the popped value, search position, top value and entry count.
// The entries live in a row of cells, the top in cell 0; a push shifts the
// whole row down one place, a pop shifts it up, and every cell compares its
// entry with the key so a search resolves in the same cycle.
// Results are registered and valid in the cycle after the transfer; one
// command is taken per cycle as long as the result register is empty or being
// drained, so the sustained rate is one item per cycle, set by the single
// output register. Reset empties the stack (fill count to zero) and drops any
// held result; entry contents are not cleared. When the receiver stalls the
// result holds in the output register and s_tready falls until it is taken.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [31:0] popped_value, [36:32] found_position,
                                 // [68:37] top_value, [73:69] entry_count,
                                 // [79:74] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import lss_pkg::*;

  logic signed [VAL_W-1:0] key;
  cmd_t                    cmd;
  logic                    accept;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  shift_t                  ctrl;
  logic signed [VAL_W-1:0] cells [DEPTH];
  logic [DEPTH-1:0]        match;
  logic [DEPTH-1:0]        occupied;
  logic                    found;
  logic [CNT_W-1:0]        position;
  logic                    empty;
  logic                    full;

  status_t                 status;
  logic signed [VAL_W-1:0] popped;
  logic [FIELD_W-1:0]      pos_out;
  logic signed [VAL_W-1:0] top;

  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_popped;
  logic [FIELD_W-1:0]      out_pos;
  logic signed [VAL_W-1:0] out_top;
  logic [FIELD_W-1:0]      out_count;

  assign key      = s_tdata[VAL_W-1:0];
  assign cmd      = cmd_t'(s_tuser);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occupied[i] = (CNT_W'(i) < count);
    end
  end

  // cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] above;
    logic signed [VAL_W-1:0] below;
    if (g == 0) begin : g_first
      assign above = key;
    end else begin : g_mid
      assign above = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign below = cells[g];
    end else begin : g_inner
      assign below = cells[g+1];
    end
    lss_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .above_value (above),
      .below_value (below),
      .key         (key),
      .value       (cells[g]),
      .match       (match[g])
    );
  end

  lss_find u_find (
    .match    (match),
    .occupied (occupied),
    .found    (found),
    .position (position)
  );

  always_comb begin
    ctrl       = '0;
    count_next = count;
    status     = ST_OK;
    popped     = '0;
    pos_out    = '0;
    top        = empty ? '0 : cells[0];
    case (cmd)
      CMD_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.push  = accept;
          count_next = count + CNT_W'(1);
          top        = key;
        end
      end
      CMD_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.pop   = accept;
          count_next = count - CNT_W'(1);
          popped     = cells[0];
          top        = (count > CNT_W'(1)) ? cells[(DEPTH > 1) ? 1 : 0] : '0;
        end
      end
      CMD_SEARCH: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (found) begin
          pos_out = FIELD_W'(position);
        end else begin
          status = ST_NOTFOUND;
        end
      end
      default: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_next = '0;
          top        = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status;
      out_popped <= popped;
      out_pos    <= pos_out;
      out_top    <= top;
      out_count  <= FIELD_W'(count_next);
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {6'd0, out_count, out_top, out_pos, out_popped};

  // fill count never goes past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // a push into a non-full stack lands on top and bumps the count
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_PUSH && !full |=>
      cells[0] == $past(key) && count == $past(count) + CNT_W'(1))
    else $error("push did not reach the top cell");

  // an empty status always reports an empty stack
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> out_count == '0 && out_top == '0)
    else $error("empty status with entries reported");

  // a successful search reports a position inside the stack
  a_search_pos: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_SEARCH && found |->
      position != '0 && position <= count)
    else $error("search position out of range");

endmodule

[tb/lifo_stack_with_search_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top_tb
// Self-checking bench for the bounded stack with value search.
// ----------------------------------------------------------------------------
// A queue of commands feeds a clocked driver on the s_ stream; each accepted
// command is run through a shadow stack kept in the bench, and the predicted
// result is queued. A clocked monitor on the m_ stream compares every result
// field by field with the oldest prediction. Both sides insert short random
// gaps, except near the end of the run. Stimulus starts with the empty and
// full corner cases, then random fill, drain and mixed phases over a small
// value pool so that searches hit, miss and meet duplicates.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top_tb;
  import lss_pkg::*;

  localparam int RANDOM_ITEMS = 870;
  localparam int CALM_ITEMS   = 100;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int POOL_SIZE    = 6;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] value;
  } stack_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] popped;
    logic [4:0]  position;
    logic [31:0] top;
    logic [4:0]  count;
  } stack_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic [1:0]  s_tuser = '0;   // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // [31:0] popped, [36:32] position, [68:37] top,
                               // [73:69] count, [79:74] zero
  logic [1:0]  m_tuser;        // [1:0] status

  stack_cmd_t    pending_cmds[$];
  stack_result_t expected_results[$];
  stack_cmd_t    drv_cmd;
  stack_result_t want;

  logic [31:0] shadow_stack[DEPTH];
  int          shadow_level = 0;

  int  gap_left = 0;
  int  stall_left = 0;
  bit  send;
  bit  idle_on = 1'b1;
  int  cycles = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  cmd_count[4];
  int  status_count[4];

  lifo_stack_with_search_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow stack: applies one command and returns the result it must give
  function automatic stack_result_t step_stack(cmd_t cmd, logic [31:0] value);
    stack_result_t res;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_level >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_stack[shadow_level] = value;
          shadow_level++;
        end
      end
      CMD_POP: begin
        if (shadow_level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_level--;
          res.popped = shadow_stack[shadow_level];
        end
      end
      CMD_SEARCH: begin
        if (shadow_level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          // first match counted from the top wins
          for (int i = 0; i < shadow_level; i++) begin
            if (res.status == ST_NOTFOUND && shadow_stack[shadow_level - 1 - i] == value) begin
              res.position = 5'(i + 1);
              res.status = ST_OK;
            end
          end
        end
      end
      default: begin
        if (shadow_level == 0) res.status = ST_EMPTY;
        else shadow_level = 0;
      end
    endcase
    res.top = (shadow_level == 0) ? 32'd0 : shadow_stack[shadow_level - 1];
    res.count = 5'(shadow_level);
    cmd_count[cmd]++;
    status_count[res.status]++;
    return res;
  endfunction

  task automatic add_cmd(cmd_t cmd, logic [31:0] value);
    stack_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  task automatic note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, exp_val, act_val);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(step_stack(drv_cmd.cmd, drv_cmd.value));
      end
      if (!s_tvalid || s_tready) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          if (pending_cmds.size() >= CALM_ITEMS && idle_on && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(0, 2);
          end else begin
            drv_cmd = pending_cmds.pop_front();
            send = 1'b1;
            s_tdata <= drv_cmd.value;
            s_tuser <= drv_cmd.cmd;
          end
        end
        s_tvalid <= send;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (pending_cmds.size() >= CALM_ITEMS && idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected transfer, top", 32'd0, m_tdata[68:37]);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser != want.status) note_mismatch("status", 32'(want.status), 32'(m_tuser));
        if (m_tdata[31:0] != want.popped) note_mismatch("popped", want.popped, m_tdata[31:0]);
        if (m_tdata[36:32] != want.position)
          note_mismatch("position", 32'(want.position), 32'(m_tdata[36:32]));
        if (m_tdata[68:37] != want.top) note_mismatch("top", want.top, m_tdata[68:37]);
        if (m_tdata[73:69] != want.count)
          note_mismatch("count", 32'(want.count), 32'(m_tdata[73:69]));
        if (m_tdata[79:74] != '0) note_mismatch("padding", 32'd0, 32'(m_tdata[79:74]));
      end
    end
  end

  // cycle count, idle stretches and timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles % 64 == 0) idle_on <= ($urandom_range(0, 2) != 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lifo_stack_with_search_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [31:0] pool[POOL_SIZE];
    logic [31:0] value;
    int          mode;
    int          run_len;
    int          r;
    int          made;
    cmd_t        cmd;

    // empty stack: pop, search and clear all report empty
    add_cmd(CMD_POP, 32'h0000_0000);
    add_cmd(CMD_SEARCH, 32'h0000_0000);
    add_cmd(CMD_CLEAR, 32'hFFFF_FFFF);
    // extreme values, hit and miss, pop, clear of a non-empty stack
    add_cmd(CMD_PUSH, 32'h8000_0000);
    add_cmd(CMD_PUSH, 32'h7FFF_FFFF);
    add_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
    add_cmd(CMD_SEARCH, 32'h0000_0000);
    add_cmd(CMD_POP, 32'h5555_5555);
    add_cmd(CMD_CLEAR, 32'hAAAA_AAAA);
    // fill to the brim with duplicates, then overflow and deep searches
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) add_cmd(CMD_PUSH, 32'h1357_9BDF);
      else if (i % 5 == 0) add_cmd(CMD_PUSH, 32'hFFFF_FFFF);
      else add_cmd(CMD_PUSH, 32'(i));
    end
    add_cmd(CMD_PUSH, 32'h0000_0000);
    add_cmd(CMD_SEARCH, 32'h1357_9BDF);
    add_cmd(CMD_SEARCH, 32'hFFFF_FFFF);

    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    for (int i = 3; i < POOL_SIZE; i++) pool[i] = $urandom();

    // random phases: mostly filling, mostly draining, or mixed
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(8, 40);
      for (int k = 0; k < run_len; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: cmd = (r < 60) ? CMD_PUSH : (r < 72) ? CMD_POP : (r < 98) ? CMD_SEARCH : CMD_CLEAR;
          1: cmd = (r < 15) ? CMD_PUSH : (r < 65) ? CMD_POP : (r < 97) ? CMD_SEARCH : CMD_CLEAR;
          default:
            cmd = (r < 35) ? CMD_PUSH : (r < 60) ? CMD_POP : (r < 96) ? CMD_SEARCH : CMD_CLEAR;
        endcase
        value = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom();
        add_cmd(cmd, value);
        made++;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("covered %0d results: %0d push, %0d pop, %0d search, %0d clear", results_seen,
             cmd_count[CMD_PUSH], cmd_count[CMD_POP], cmd_count[CMD_SEARCH],
             cmd_count[CMD_CLEAR]);
    $display("statuses: %0d ok, %0d empty, %0d full, %0d not found; %0d mismatches",
             status_count[ST_OK], status_count[ST_EMPTY], status_count[ST_FULL],
             status_count[ST_NOTFOUND], mismatches);
    if (mismatches == 0) begin
      $display("lifo_stack_with_search_top_tb OK");
    end else begin
      $display("lifo_stack_with_search_top_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lss_pkg.sv
rtl/lss_cell.sv
rtl/lss_find.sv
rtl/lifo_stack_with_search_top.sv
tb/lifo_stack_with_search_top_tb.sv
